>>> design/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
package spq_pkg;

    localparam int ID_W    = 16;
    localparam int PRIO_W  = 16;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    typedef struct packed {
        logic              ins;
        logic              rem;
        logic              clr;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } ctrl_t;

endpackage

>>> design/spq_cell.sv
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
module spq_cell
    import spq_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  ctrl_t  ctrl,
    input  entry_t left_entry,
    input  logic   left_place,
    input  entry_t right_entry,
    output entry_t entry,
    output logic   place
);

    logic              valid_reg;
    logic              valid_next;
    logic [ID_W-1:0]   id_reg;
    logic [ID_W-1:0]   id_next;
    logic [PRIO_W-1:0] prio_reg;
    logic [PRIO_W-1:0] prio_next;
    logic              lt;

    assign entry = '{valid: valid_reg, id: id_reg, prio: prio_reg};

    always_comb
    begin
        lt         = valid_reg && (ctrl.prio < prio_reg);
        place      = lt || !valid_reg;
        valid_next = valid_reg;
        id_next    = id_reg;
        prio_next  = prio_reg;
        if (ctrl.clr)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.rem)
        begin
            valid_next = right_entry.valid;
            id_next    = right_entry.id;
            prio_next  = right_entry.prio;
        end
        else if (ctrl.ins)
        begin
            if (left_place)
            begin
                valid_next = left_entry.valid;
                id_next    = left_entry.id;
                prio_next  = left_entry.prio;
            end
            else if (place)
            begin
                valid_next = 1'b1;
                id_next    = ctrl.id;
                prio_next  = ctrl.prio;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        prio_reg <= prio_next;
    end

endmodule

>>> design/sorted_priority_queue.sv
// Top level of the sorted priority queue: command decode, cell chain and result register.
// Usage:
// A request is taken at a rising clock edge where start is high and busy is low.
// busy is never raised, so one request can be issued in every cycle.
// The command field selects insert, remove of the head entry, or clear.
// Every slot of the chain compares the new priority against its own entry in
// the same cycle and either keeps its entry, takes its neighbor's, takes the new
// one or, on clear, drops it, so every request updates the whole cell chain together.
// The result appears in the cycle after the request, with done high for exactly
// one cycle; the receiver cannot stall it and must take it in that cycle.
// Throughput is one request per cycle.
// Equal priorities leave in arrival order.
// head_id and head_priority are zero unless the request was a successful remove.
// status reports a remove on an empty queue or an insert refused when full.
// count gives the number of entries held after the request.
// Reset empties the queue and clears the result strobe.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [CMD_W-1:0]   command,
    input  logic [ID_W-1:0]    entry_id,
    input  logic [PRIO_W-1:0]  entry_priority,
    output logic               done,
    output logic [ID_W-1:0]    head_id,
    output logic [PRIO_W-1:0]  head_priority,
    output logic [STAT_W-1:0]  status,
    output logic [COUNT_W-1:0] count
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic               done_reg;
    logic [ID_W-1:0]    head_id_reg;
    logic [ID_W-1:0]    head_id_next;
    logic [PRIO_W-1:0]  head_prio_reg;
    logic [PRIO_W-1:0]  head_prio_next;
    logic [STAT_W-1:0]  status_reg;
    logic [STAT_W-1:0]  status_next;
    logic [COUNT_W-1:0] count_out_reg;
    logic               accept;
    logic               full;
    logic               empty;
    ctrl_t              ctrl;
    entry_t             cell_entry [DEPTH];
    logic               cell_place [DEPTH];

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == CW'(DEPTH));
    assign empty  = (count_reg == '0);

    always_comb
    begin
        ctrl           = '0;
        ctrl.id        = entry_id;
        ctrl.prio      = entry_priority;
        status_next    = ST_DONE;
        count_next     = count_reg;
        head_id_next   = '0;
        head_prio_next = '0;
        if (accept)
        begin
            unique case (command)
                CMD_INSERT:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        ctrl.ins   = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                CMD_REMOVE:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        ctrl.rem       = 1'b1;
                        count_next     = count_reg - 1'b1;
                        head_id_next   = cell_entry[0].id;
                        head_prio_next = cell_entry[0].prio;
                    end
                end
                CMD_CLEAR:
                begin
                    ctrl.clr   = 1'b1;
                    count_next = '0;
                end
                default:
                begin
                    status_next = ST_DONE;
                end
            endcase
        end
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        entry_t left_e;
        entry_t right_e;
        logic   left_p;

        if (i == 0)
        begin : g_head
            assign left_e = '0;
            assign left_p = 1'b0;
        end
        else
        begin : g_mid
            assign left_e = cell_entry[i-1];
            assign left_p = cell_place[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_e = '0;
        end
        else
        begin : g_body
            assign right_e = cell_entry[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .left_entry  (left_e),
            .left_place  (left_p),
            .right_entry (right_e),
            .entry       (cell_entry[i]),
            .place       (cell_place[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        head_id_reg   <= head_id_next;
        head_prio_reg <= head_prio_next;
        status_reg    <= status_next;
        count_out_reg <= COUNT_W'(count_next);
    end

    assign done          = done_reg;
    assign head_id       = head_id_reg;
    assign head_priority = head_prio_reg;
    assign status        = status_reg;
    assign count         = count_out_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("Entry count exceeds depth.");

    a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) == cell_entry[0].valid)
        else $error("Head slot validity disagrees with entry count.");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("Result strobe missing after a request.");

    a_full_refusal: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_FULL) |-> full)
        else $error("Insert refused while the queue was not full.");

    a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
        cell_entry[0].valid && cell_entry[1].valid |->
            cell_entry[0].prio <= cell_entry[1].prio)
        else $error("Head slots out of priority order.");
`endif

endmodule
